/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros used by the bssg_checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is masked while reset is asserted.
`define BSSG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define BSSG_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/bssg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bssg_pkg
// Shared types and constants of the broadcast shape and stride generator.
// ----------------------------------------------------------------------------
package bssg_pkg;

  // Field widths.
  localparam int unsigned DIM_W    = 16;
  localparam int unsigned STRIDE_W = 32;
  localparam int unsigned PROD_W   = DIM_W + STRIDE_W;

  // Largest broadcast rank accepted without error.
  localparam logic [3:0] MAX_RANK = 4'd8;

  // Saturation points.
  localparam logic [STRIDE_W-1:0] SAT32    = '1;
  localparam logic [3:0]          RANK_SAT = 4'd15;
  localparam logic [2:0]          POS_MAX  = 3'd7;

  // Status codes reported with every item.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INCOMPAT = 2'd1,
    ST_RANK     = 2'd2
  } status_t;

endpackage

/* rtl/core/broadcast_shape_stride_generator.sv */
`timescale 1ns / 1ps
// An accepted item is held in the input register; its result is computed from
// it and captured in the output register, from which it is taken.
// Throughput: one item per cycle while the result channel does not stall, set
// by the saturating 32x16 stride multiply that feeds the running strides and element count back.
// Reset (synchronous, active low) empties both stages and returns the running
// strides, element count, dimension counter, status and overflow to idle values.
// ----------------------------------------------------------------------------
// broadcast_shape_stride_generator
// Computes the broadcast output size and both operands' element strides for
// one dimension pair per item, innermost dimension first.
// ----------------------------------------------------------------------------
module broadcast_shape_stride_generator (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_present_a,
  input  logic [15:0] in_size_a,
  input  logic        in_present_b,
  input  logic [15:0] in_size_b,
  input  logic        in_last,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_size,
  output logic [31:0] out_stride_a,
  output logic [31:0] out_stride_b,
  output logic [2:0]  out_dim_position,
  output logic        out_end_of_shape,
  output logic [1:0]  out_status,
  output logic [3:0]  out_rank,
  output logic [31:0] out_numel,
  output logic        out_overflow
);

  // Input register
  logic                            s1_valid_r;
  logic                            s1_present_a_r;
  logic [bssg_pkg::DIM_W-1:0]      s1_size_a_r;
  logic                            s1_present_b_r;
  logic [bssg_pkg::DIM_W-1:0]      s1_size_b_r;
  logic                            s1_last_r;

  // Running shape state
  logic [bssg_pkg::STRIDE_W-1:0]   nat_a_r, nat_a_nxt;
  logic [bssg_pkg::STRIDE_W-1:0]   nat_b_r, nat_b_nxt;
  logic [bssg_pkg::STRIDE_W-1:0]   numel_r, numel_nxt;
  logic [3:0]                      dim_cnt_r, dim_cnt_nxt;
  bssg_pkg::status_t               err_r, err_nxt;
  logic                            ovf_r, ovf_nxt;

  // Result register
  logic                            s2_valid_r;
  logic [bssg_pkg::DIM_W-1:0]      s2_size_r;
  logic [bssg_pkg::STRIDE_W-1:0]   s2_stride_a_r;
  logic [bssg_pkg::STRIDE_W-1:0]   s2_stride_b_r;
  logic [2:0]                      s2_pos_r;
  logic                            s2_last_r;
  bssg_pkg::status_t               s2_status_r;
  logic [3:0]                      s2_rank_r;
  logic [bssg_pkg::STRIDE_W-1:0]   s2_numel_r;
  logic                            s2_ovf_r;

  // Datapath signals
  logic                            s1_adv;
  logic [bssg_pkg::DIM_W-1:0]      size_a_eff, size_b_eff, size_o;
  logic                            incompat;
  bssg_pkg::status_t               err_new;
  logic [bssg_pkg::STRIDE_W-1:0]   stride_a, stride_b;
  logic [bssg_pkg::PROD_W-1:0]     prod_a, prod_b, prod_o;
  logic                            sat_a, sat_b, sat_o;
  logic [bssg_pkg::STRIDE_W-1:0]   nat_a_mul, nat_b_mul, numel_mul;
  logic                            ovf_new;
  logic [2:0]                      pos;
  logic [3:0]                      rank;

  // Handshake: the input stage moves on whenever the result register is free
  // or is being emptied this cycle.
  assign s1_adv   = s1_valid_r && (!s2_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;

  // Capture a new item whenever the input register is free or moves on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_present_a_r <= in_present_a;
      s1_size_a_r    <= in_size_a;
      s1_present_b_r <= in_present_b;
      s1_size_b_r    <= in_size_b;
      s1_last_r      <= in_last;
    end
  end

  // Effective sizes, output size and compatibility.
  always_comb begin
    size_a_eff = s1_present_a_r ? s1_size_a_r : bssg_pkg::DIM_W'(1);
    size_b_eff = s1_present_b_r ? s1_size_b_r : bssg_pkg::DIM_W'(1);
    size_o     = (size_a_eff > size_b_eff) ? size_a_eff : size_b_eff;
    incompat   = (size_a_eff != size_b_eff) && (size_a_eff != bssg_pkg::DIM_W'(1))
                 && (size_b_eff != bssg_pkg::DIM_W'(1));
  end

  // Sticky status: a rank error overrides an incompatibility.
  always_comb begin
    err_new = err_r;
    if (err_r == bssg_pkg::ST_OK && incompat) begin
      err_new = bssg_pkg::ST_INCOMPAT;
    end
    if (dim_cnt_r >= bssg_pkg::MAX_RANK) begin
      err_new = bssg_pkg::ST_RANK;
    end
  end

  // Broadcast strides: zero when absent or stretched from size one.
  always_comb begin
    stride_a = nat_a_r;
    stride_b = nat_b_r;
    if (!s1_present_a_r || (size_a_eff == bssg_pkg::DIM_W'(1)
                            && size_o > bssg_pkg::DIM_W'(1))) begin
      stride_a = '0;
    end
    if (!s1_present_b_r || (size_b_eff == bssg_pkg::DIM_W'(1)
                            && size_o > bssg_pkg::DIM_W'(1))) begin
      stride_b = '0;
    end
  end

  // Saturating running products, one 32x16 multiply each.
  always_comb begin
    prod_a    = bssg_pkg::PROD_W'(nat_a_r) * bssg_pkg::PROD_W'(size_a_eff);
    prod_b    = bssg_pkg::PROD_W'(nat_b_r) * bssg_pkg::PROD_W'(size_b_eff);
    prod_o    = bssg_pkg::PROD_W'(numel_r) * bssg_pkg::PROD_W'(size_o);
    sat_a     = |prod_a[bssg_pkg::PROD_W-1:bssg_pkg::STRIDE_W];
    sat_b     = |prod_b[bssg_pkg::PROD_W-1:bssg_pkg::STRIDE_W];
    sat_o     = |prod_o[bssg_pkg::PROD_W-1:bssg_pkg::STRIDE_W];
    nat_a_mul = sat_a ? bssg_pkg::SAT32 : prod_a[bssg_pkg::STRIDE_W-1:0];
    nat_b_mul = sat_b ? bssg_pkg::SAT32 : prod_b[bssg_pkg::STRIDE_W-1:0];
    numel_mul = sat_o ? bssg_pkg::SAT32 : prod_o[bssg_pkg::STRIDE_W-1:0];
    ovf_new   = ovf_r || (s1_present_a_r && sat_a) || (s1_present_b_r && sat_b) || sat_o;
  end

  // Position and rank, both saturating.
  always_comb begin
    pos  = (dim_cnt_r > 4'(bssg_pkg::POS_MAX)) ? bssg_pkg::POS_MAX : dim_cnt_r[2:0];
    rank = (dim_cnt_r != bssg_pkg::RANK_SAT) ? dim_cnt_r + 4'd1 : bssg_pkg::RANK_SAT;
  end

  // Next state: the last item of a shape returns everything to idle.
  always_comb begin
    if (s1_last_r) begin
      nat_a_nxt   = bssg_pkg::STRIDE_W'(1);
      nat_b_nxt   = bssg_pkg::STRIDE_W'(1);
      numel_nxt   = bssg_pkg::STRIDE_W'(1);
      dim_cnt_nxt = '0;
      err_nxt     = bssg_pkg::ST_OK;
      ovf_nxt     = 1'b0;
    end else begin
      nat_a_nxt   = s1_present_a_r ? nat_a_mul : nat_a_r;
      nat_b_nxt   = s1_present_b_r ? nat_b_mul : nat_b_r;
      numel_nxt   = numel_mul;
      dim_cnt_nxt = rank;
      err_nxt     = err_new;
      ovf_nxt     = ovf_new;
    end
  end

  // Shape state advances with each item that leaves the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nat_a_r   <= bssg_pkg::STRIDE_W'(1);
      nat_b_r   <= bssg_pkg::STRIDE_W'(1);
      numel_r   <= bssg_pkg::STRIDE_W'(1);
      dim_cnt_r <= '0;
      err_r     <= bssg_pkg::ST_OK;
      ovf_r     <= 1'b0;
    end else if (s1_adv) begin
      nat_a_r   <= nat_a_nxt;
      nat_b_r   <= nat_b_nxt;
      numel_r   <= numel_nxt;
      dim_cnt_r <= dim_cnt_nxt;
      err_r     <= err_nxt;
      ovf_r     <= ovf_nxt;
    end
  end

  // Result register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (!s2_valid_r || !out_stall) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_size_r     <= size_o;
      s2_stride_a_r <= stride_a;
      s2_stride_b_r <= stride_b;
      s2_pos_r      <= pos;
      s2_last_r     <= s1_last_r;
      s2_status_r   <= err_new;
      s2_rank_r     <= rank;
      s2_numel_r    <= numel_mul;
      s2_ovf_r      <= ovf_new;
    end
  end

  // Output ports.
  assign out_valid        = s2_valid_r;
  assign out_size         = s2_size_r;
  assign out_stride_a     = s2_stride_a_r;
  assign out_stride_b     = s2_stride_b_r;
  assign out_dim_position = s2_pos_r;
  assign out_end_of_shape = s2_last_r;
  assign out_status       = s2_status_r;
  assign out_rank         = s2_rank_r;
  assign out_numel        = s2_numel_r;
  assign out_overflow     = s2_ovf_r;

endmodule

/* rtl/core/bssg_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bssg_checker
// Port-level checks of the broadcast shape and stride generator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bssg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_present_a,
  input logic [15:0] in_size_a,
  input logic        in_present_b,
  input logic [15:0] in_size_b,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_size,
  input logic [31:0] out_stride_a,
  input logic [31:0] out_stride_b,
  input logic [2:0]  out_dim_position,
  input logic        out_end_of_shape,
  input logic [1:0]  out_status,
  input logic [3:0]  out_rank,
  input logic [31:0] out_numel,
  input logic        out_overflow
);

  // A stalled result item holds its value.
  `BSSG_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_size) && $stable(out_stride_a) && $stable(out_stride_b) && $stable(out_numel) && $stable(out_status) && $stable(out_rank), "stalled item changed")

  // Below saturation the rank is one more than the position.
  `BSSG_ASSERT(a_rank_pos, out_valid && out_dim_position != bssg_pkg::POS_MAX |-> out_rank == 4'(out_dim_position) + 4'd1, "rank does not follow position")

  // A rank above the limit always reports the rank error.
  `BSSG_ASSERT(a_rank_err, out_valid && out_rank > bssg_pkg::MAX_RANK |-> out_status == bssg_pkg::ST_RANK, "rank error not reported")

  // The rank error is only reported once the limit is passed.
  `BSSG_ASSERT(a_err_rank, out_valid && out_status == bssg_pkg::ST_RANK |-> out_rank > bssg_pkg::MAX_RANK, "spurious rank error")

  // Reset empties the result register.
  `BSSG_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind broadcast_shape_stride_generator bssg_checker u_bssg_checker (.*);

/* tb/bssg_stride_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bssg_stride_checker
// Watches both channels of the broadcast shape and stride generator. Each
// accepted dimension item runs through a local model of the running strides,
// element count, rank and status. Each accepted result is compared against
// the oldest predicted result.
// ----------------------------------------------------------------------------
module bssg_stride_checker (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel, observed
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_present_a,
  input  logic [15:0] in_size_a,
  input  logic        in_present_b,
  input  logic [15:0] in_size_b,
  input  logic        in_last,
  // Result channel, observed
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] out_size,
  input  logic [31:0] out_stride_a,
  input  logic [31:0] out_stride_b,
  input  logic [2:0]  out_dim_position,
  input  logic        out_end_of_shape,
  input  logic [1:0]  out_status,
  input  logic [3:0]  out_rank,
  input  logic [31:0] out_numel,
  input  logic        out_overflow,
  // Totals for the testbench top
  output int          mismatches,
  output int          pending,
  output int          dims_checked,
  output int          incompat_shapes,
  output int          rank_shapes,
  output int          saturated_shapes
);

  typedef struct packed {
    logic [15:0]         size;
    logic [31:0]         stride_a;
    logic [31:0]         stride_b;
    logic [2:0]          dim_position;
    logic                end_of_shape;
    bssg_pkg::status_t   status;
    logic [3:0]          rank;
    logic [31:0]         numel;
    logic                overflow;
  } dim_result_t;

  // Running state of the shape pair currently being walked.
  logic [31:0]       run_stride_a;
  logic [31:0]       run_stride_b;
  logic [31:0]       elem_count;
  logic [3:0]        dims_seen;
  bssg_pkg::status_t shape_status;
  logic              sat_seen;

  dim_result_t pending_dims[$];

  // Return the shape-pair state to its idle values.
  function automatic void clear_shape();
    run_stride_a = 32'd1;
    run_stride_b = 32'd1;
    elem_count   = 32'd1;
    dims_seen    = 4'd0;
    shape_status = bssg_pkg::ST_OK;
    sat_seen     = 1'b0;
  endfunction

  // Saturating 32-bit product; the top bit flags that the clamp was applied.
  function automatic logic [32:0] clamp_mul(logic [31:0] x, logic [31:0] y);
    logic [63:0] prod;
    prod = 64'(x) * 64'(y);
    if (prod > 64'(bssg_pkg::SAT32)) return {1'b1, bssg_pkg::SAT32};
    return {1'b0, prod[31:0]};
  endfunction

  // Advance the shape state by one dimension pair and return its result.
  function automatic dim_result_t predict_dim(logic pa, logic [15:0] sza, logic pb,
                                              logic [15:0] szb, logic is_last);
    dim_result_t r;
    logic [15:0] eff_a;
    logic [15:0] eff_b;
    logic [15:0] eff_o;
    logic [32:0] prod;
    eff_a = pa ? sza : 16'd1;
    eff_b = pb ? szb : 16'd1;
    eff_o = (eff_a > eff_b) ? eff_a : eff_b;

    // Incompatible sizes stick, but a rank error overrides them.
    if (eff_a != eff_b && eff_a != 16'd1 && eff_b != 16'd1 &&
        shape_status == bssg_pkg::ST_OK)
      shape_status = bssg_pkg::ST_INCOMPAT;
    if (dims_seen >= bssg_pkg::MAX_RANK) shape_status = bssg_pkg::ST_RANK;

    // A missing dimension, or size 1 against a larger output, broadcasts.
    r.stride_a = (!pa || (eff_a == 16'd1 && eff_o > 16'd1)) ? 32'd0 : run_stride_a;
    r.stride_b = (!pb || (eff_b == 16'd1 && eff_o > 16'd1)) ? 32'd0 : run_stride_b;

    if (pa) begin
      prod = clamp_mul(run_stride_a, {16'd0, eff_a});
      run_stride_a = prod[31:0];
      sat_seen = sat_seen | prod[32];
    end
    if (pb) begin
      prod = clamp_mul(run_stride_b, {16'd0, eff_b});
      run_stride_b = prod[31:0];
      sat_seen = sat_seen | prod[32];
    end
    prod = clamp_mul(elem_count, {16'd0, eff_o});
    elem_count = prod[31:0];
    sat_seen = sat_seen | prod[32];

    r.dim_position = (dims_seen > 4'd7) ? bssg_pkg::POS_MAX : dims_seen[2:0];
    if (dims_seen < bssg_pkg::RANK_SAT) dims_seen = dims_seen + 4'd1;

    r.size         = eff_o;
    r.end_of_shape = is_last;
    r.status       = shape_status;
    r.rank         = dims_seen;
    r.numel        = elem_count;
    r.overflow     = sat_seen;
    if (is_last) clear_shape();
    return r;
  endfunction

  function automatic void show_dim(string tag, dim_result_t r);
    $display("  %s size=%0d stride_a=%0d stride_b=%0d pos=%0d end=%0b",
             tag, r.size, r.stride_a, r.stride_b, r.dim_position, r.end_of_shape);
    $display("            status=%0d rank=%0d numel=%0d ovf=%0b",
             r.status, r.rank, r.numel, r.overflow);
  endfunction

  // Compare accepted results first, then predict from the accepted item.
  always @(posedge clk) begin : watch
    dim_result_t got;
    dim_result_t want;
    if (!rst_n) begin
      clear_shape();
      pending_dims.delete();
      mismatches       = 0;
      dims_checked     = 0;
      incompat_shapes  = 0;
      rank_shapes      = 0;
      saturated_shapes = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{size: out_size, stride_a: out_stride_a, stride_b: out_stride_b,
                dim_position: out_dim_position, end_of_shape: out_end_of_shape,
                status: bssg_pkg::status_t'(out_status), rank: out_rank,
                numel: out_numel, overflow: out_overflow};
        if (pending_dims.size() == 0) begin
          if (mismatches < 10) begin
            $display("[%0t] Result arrived with no item outstanding.", $time);
            show_dim("actual:  ", got);
          end
          mismatches++;
        end else begin
          want = pending_dims.pop_front();
          dims_checked++;
          if (got.size !== want.size || got.stride_a !== want.stride_a ||
              got.stride_b !== want.stride_b || got.dim_position !== want.dim_position ||
              got.end_of_shape !== want.end_of_shape || got.status !== want.status ||
              got.rank !== want.rank || got.numel !== want.numel ||
              got.overflow !== want.overflow) begin
            if (mismatches < 10) begin
              $display("[%0t] Dimension result mismatch.", $time);
              show_dim("expected:", want);
              show_dim("actual:  ", got);
            end
            mismatches++;
          end
        end
      end

      if (in_valid && !in_stall) begin
        want = predict_dim(in_present_a, in_size_a, in_present_b, in_size_b, in_last);
        pending_dims.push_back(want);
        if (want.end_of_shape) begin
          if (want.status == bssg_pkg::ST_INCOMPAT) incompat_shapes++;
          if (want.status == bssg_pkg::ST_RANK) rank_shapes++;
          if (want.overflow) saturated_shapes++;
        end
      end
    end
    pending = pending_dims.size();
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives dimension pairs into the broadcast shape and stride generator: a
// directed set of corner shapes, then random shape pairs under three idling
// patterns and one long output hold-off. The checker beside the block
// predicts and compares; this module reports the verdict.
// ----------------------------------------------------------------------------
module tb;

  localparam int PHASE_ITEMS = 560;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 200000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_present_a;
  logic [15:0] in_size_a;
  logic        in_present_b;
  logic [15:0] in_size_b;
  logic        in_last;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_size;
  logic [31:0] out_stride_a;
  logic [31:0] out_stride_b;
  logic [2:0]  out_dim_position;
  logic        out_end_of_shape;
  logic [1:0]  out_status;
  logic [3:0]  out_rank;
  logic [31:0] out_numel;
  logic        out_overflow;

  int mismatches;
  int pending;
  int dims_checked;
  int incompat_shapes;
  int rank_shapes;
  int saturated_shapes;

  int src_idle_pct;
  int sink_stall_pct;
  logic hold_req;
  int items_sent;
  int shapes_sent;
  int unsigned cycle_count;

  broadcast_shape_stride_generator u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_present_a     (in_present_a),
    .in_size_a        (in_size_a),
    .in_present_b     (in_present_b),
    .in_size_b        (in_size_b),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_size         (out_size),
    .out_stride_a     (out_stride_a),
    .out_stride_b     (out_stride_b),
    .out_dim_position (out_dim_position),
    .out_end_of_shape (out_end_of_shape),
    .out_status       (out_status),
    .out_rank         (out_rank),
    .out_numel        (out_numel),
    .out_overflow     (out_overflow)
  );

  bssg_stride_checker u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_present_a     (in_present_a),
    .in_size_a        (in_size_a),
    .in_present_b     (in_present_b),
    .in_size_b        (in_size_b),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_size         (out_size),
    .out_stride_a     (out_stride_a),
    .out_stride_b     (out_stride_b),
    .out_dim_position (out_dim_position),
    .out_end_of_shape (out_end_of_shape),
    .out_status       (out_status),
    .out_rank         (out_rank),
    .out_numel        (out_numel),
    .out_overflow     (out_overflow),
    .mismatches       (mismatches),
    .pending          (pending),
    .dims_checked     (dims_checked),
    .incompat_shapes  (incompat_shapes),
    .rank_shapes      (rank_shapes),
    .saturated_shapes (saturated_shapes)
  );

  // Free-running clock, 10 ns period.
  initial begin : clock_gen
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle counter that ends a hung run.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding.", CYCLE_LIMIT, pending);
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off when requested.
  initial begin : result_sink
    int hold_left;
    bit hold_served;
    hold_left   = 0;
    hold_served = 1'b0;
    out_stall   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_served) begin
        hold_left   = HOLD_CYCLES;
        hold_served = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < sink_stall_pct);
      end
    end
  end

  // Offer one dimension pair, idling first at random, and hold it until taken.
  task automatic send_dim(logic pa, logic [15:0] sza, logic pb, logic [15:0] szb,
                          logic is_last);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_present_a <= pa;
    in_size_a    <= sza;
    in_present_b <= pb;
    in_size_b    <= szb;
    in_last      <= is_last;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (is_last) shapes_sent++;
  endtask

  // Mostly small sizes, with ones, zeros and the odd large value.
  function automatic logic [15:0] pick_size();
    case ($urandom_range(9))
      0:       return 16'd0;
      6, 7:    return 16'd1;
      8:       return 16'($urandom_range(9, 300));
      9:       return 16'($urandom);
      default: return 16'($urandom_range(1, 8));
    endcase
  endfunction

  // One shape pair, right-aligned; some dimensions are noise.
  task automatic send_random_shape();
    int rank;
    int rank_a;
    int rank_b;
    int kind;
    logic [15:0] s;
    logic [15:0] sa;
    logic [15:0] sb;
    logic pa;
    logic pb;
    rank   = ($urandom_range(9) == 0) ? $urandom_range(9, 18) : $urandom_range(1, 8);
    rank_a = ($urandom_range(2) == 0) ? $urandom_range(0, rank) : rank;
    rank_b = ($urandom_range(2) == 0) ? $urandom_range(0, rank) : rank;
    for (int d = 0; d < rank; d++) begin
      kind = $urandom_range(99);
      s  = pick_size();
      pa = (d < rank_a);
      pb = (d < rank_b);
      sa = ($urandom_range(3) == 0) ? 16'd1 : s;
      sb = ($urandom_range(3) == 0) ? 16'd1 : s;
      if (kind >= 85) begin
        sa = 16'($urandom);
        sb = 16'($urandom);
        pa = 1'($urandom);
        pb = 1'($urandom);
      end else if (kind >= 70) begin
        sa = pick_size();
        sb = pick_size();
      end
      // An absent operand's size field carries junk.
      if (!pa) sa = 16'($urandom);
      if (!pb) sb = 16'($urandom);
      send_dim(pa, sa, pb, sb, d == rank - 1);
    end
  endtask

  task automatic run_random(int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) send_random_shape();
  endtask

  initial begin : stimulus
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_present_a   = 1'b0;
    in_size_a      = 16'd0;
    in_present_b   = 1'b0;
    in_size_b      = 16'd0;
    in_last        = 1'b0;
    hold_req       = 1'b0;
    items_sent     = 0;
    shapes_sent    = 0;
    src_idle_pct   = 25;
    sink_stall_pct = 63;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Rank-1 shape of ones.
    send_dim(1'b1, 16'd1, 1'b1, 16'd1, 1'b1);
    // Largest sizes in three dimensions: the running products saturate.
    send_dim(1'b1, 16'hFFFF, 1'b1, 16'hFFFF, 1'b0);
    send_dim(1'b1, 16'hFFFF, 1'b1, 16'hFFFF, 1'b0);
    send_dim(1'b1, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1);
    // Absent A, size 1 against 9, equal zeros, zero against 5, both absent.
    send_dim(1'b0, 16'hFFFF, 1'b1, 16'd7, 1'b0);
    send_dim(1'b1, 16'd1, 1'b1, 16'd9, 1'b0);
    send_dim(1'b1, 16'd0, 1'b1, 16'd0, 1'b0);
    send_dim(1'b1, 16'd0, 1'b1, 16'd5, 1'b0);
    send_dim(1'b0, 16'h5A5A, 1'b0, 16'hA5A5, 1'b1);
    // Sixteen dimensions: rank error, position and rank saturate.
    for (int d = 0; d < 16; d++)
      send_dim(1'b1, 16'($urandom_range(1, 3)), 1'b1, 16'd1, d == 15);

    run_random(PHASE_ITEMS);

    src_idle_pct   = 63;
    sink_stall_pct = 25;
    run_random(PHASE_ITEMS);

    // No idling; the long hold-off backs the block up into its input.
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_req       = 1'b1;
    run_random(PHASE_ITEMS);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Sent %0d dimension items in %0d shape pairs; %0d results checked.",
             items_sent, shapes_sent, dims_checked);
    $display("Shapes ending incompatible: %0d, over the rank limit: %0d, saturated: %0d.",
             incompat_shapes, rank_shapes, saturated_shapes);
    if (mismatches == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results outstanding.", mismatches, pending);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
